@@ rtl/hmesh_pkg.sv @@
// ----------------------------------------------------------------------------
// hmesh_pkg
// Shared types and constants of the heightmap mesh generator.
// ----------------------------------------------------------------------------
package hmesh_pkg;

    // Configuration port geometry: five 32-bit registers at byte offsets 4*i.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0]
    {
        REG_MAP_WIDTH  = 3'd0,
        REG_MAP_ROWS   = 3'd1,
        REG_MAX_HEIGHT = 3'd2,
        REG_U_STEP     = 3'd3,
        REG_V_STEP     = 3'd4
    } reg_idx_t;

    typedef struct packed
    {
        logic [10:0] map_width;
        logic [10:0] map_rows;
        logic [15:0] max_height;
        logic [16:0] u_step;
        logic [16:0] v_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        map_width:  11'd1024,
        map_rows:   11'd1024,
        max_height: 16'd256,
        u_step:     17'd64,
        v_step:     17'd64
    };

    // Height arithmetic: the channel sum times max_height, divided by 3*255.
    localparam int CHAN_MAX     = 255;
    localparam int CHAN_COUNT   = 3;
    localparam int HEIGHT_DIV   = CHAN_COUNT * CHAN_MAX;
    localparam int SUM_W        = 10;
    localparam int HEIGHT_W     = 16;
    localparam int SCALED_W     = SUM_W + HEIGHT_W;
    localparam int HEIGHT_SHIFT = 36;
    localparam int RECIP_W      = 27;

    // Rounded-up reciprocal of the divisor. With a shift of 36 the error term
    // stays below one part in the divisor for every scaled value below 2^26,
    // so the truncated product is the exact floor of the quotient.
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << HEIGHT_SHIFT) + 64'(HEIGHT_DIV) - 64'd1) / 64'(HEIGHT_DIV);
    localparam logic [RECIP_W-1:0] HEIGHT_RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam int TEX_W = 17;
    localparam logic [TEX_W-1:0] TEX_ONE = 17'h10000;

    localparam int POS_W = 10;

    // Corner heights of one quad.
    typedef struct packed
    {
        logic [HEIGHT_W-1:0] above_left;
        logic [HEIGHT_W-1:0] left;
        logic [HEIGHT_W-1:0] above;
        logic [HEIGHT_W-1:0] here;
    } heights_t;

endpackage

@@ rtl/hmesh_ram.sv @@
// ----------------------------------------------------------------------------
// hmesh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hmesh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ rtl/hmesh_regs.sv @@
// ----------------------------------------------------------------------------
// hmesh_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module hmesh_regs
    import hmesh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAP_WIDTH:  cfg_reg.map_width  <= pwdata[10:0];
                REG_MAP_ROWS:   cfg_reg.map_rows   <= pwdata[10:0];
                REG_MAX_HEIGHT: cfg_reg.max_height <= pwdata[15:0];
                REG_U_STEP:     cfg_reg.u_step     <= pwdata[16:0];
                REG_V_STEP:     cfg_reg.v_step     <= pwdata[16:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAP_WIDTH:  prdata = DATA_W'(cfg_reg.map_width);
            REG_MAP_ROWS:   prdata = DATA_W'(cfg_reg.map_rows);
            REG_MAX_HEIGHT: prdata = DATA_W'(cfg_reg.max_height);
            REG_U_STEP:     prdata = DATA_W'(cfg_reg.u_step);
            REG_V_STEP:     prdata = DATA_W'(cfg_reg.v_step);
            default:        prdata = '0;
        endcase
    end

endmodule

@@ rtl/hmesh_front.sv @@
// ----------------------------------------------------------------------------
// hmesh_front
// Pixel intake: height computation, line store and raster counters. Emits one
// quad request per interior pixel.
// ----------------------------------------------------------------------------
module hmesh_front
    import hmesh_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   red,
    input  logic [7:0]                   green,
    input  logic [7:0]                   blue,
    output logic                         job_push,
    input  logic                         job_full,
    output logic [$clog2(MAX_WIDTH)-1:0] job_x,
    output logic [$clog2(MAX_ROWS)-1:0]  job_z,
    output heights_t                     job_h
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int XCW = XW + 1;
    localparam int ZW  = $clog2(MAX_ROWS);
    localparam int ZCW = ZW + 1;

    logic [XW-1:0] col_reg;
    logic [ZW-1:0] row_reg;
    logic [HEIGHT_W-1:0] left_reg;
    logic [HEIGHT_W-1:0] above_left_reg;

    // Stage B: scaled sum waits for the multiply by the reciprocal.
    logic                b_valid_reg;
    logic [SCALED_W-1:0] b_scaled_reg;
    logic [XW-1:0]       b_x_reg;
    logic [ZW-1:0]       b_z_reg;

    // Stage C: finished height, written back and forwarded as a quad request.
    logic                c_valid_reg;
    logic [HEIGHT_W-1:0] c_h_reg;
    logic [HEIGHT_W-1:0] c_above_reg;
    logic [XW-1:0]       c_x_reg;
    logic [ZW-1:0]       c_z_reg;

    logic [XCW-1:0] width_eff;
    logic [ZCW-1:0] rows_eff;
    logic [XCW-1:0] col_inc;
    logic [ZCW-1:0] row_inc;
    logic           col_wrap;
    logic           row_wrap;
    logic           accept;
    logic           b_to_c;
    logic           c_emit;
    logic           c_done;
    logic [SUM_W-1:0]            chan_sum;
    logic [SCALED_W-1:0]         scaled;
    logic [SCALED_W+RECIP_W-1:0] quot_prod;
    logic [HEIGHT_W-1:0]         ram_rdata;

    always_comb
    begin
        if (cfg.map_width < 11'd2)
            width_eff = XCW'(2);
        else if (32'(cfg.map_width) > 32'(MAX_WIDTH))
            width_eff = XCW'(MAX_WIDTH);
        else
            width_eff = XCW'(cfg.map_width);

        if (cfg.map_rows < 11'd2)
            rows_eff = ZCW'(2);
        else if (32'(cfg.map_rows) > 32'(MAX_ROWS))
            rows_eff = ZCW'(MAX_ROWS);
        else
            rows_eff = ZCW'(cfg.map_rows);
    end

    assign col_inc  = XCW'(col_reg) + XCW'(1);
    assign row_inc  = ZCW'(row_reg) + ZCW'(1);
    assign col_wrap = col_inc >= width_eff;
    assign row_wrap = row_inc >= rows_eff;

    // One pixel at a time in stage B, so a line store write always lands
    // before the same column is read again one row later.
    assign full   = b_valid_reg;
    assign accept = push && !b_valid_reg;

    assign c_emit = (c_x_reg != '0) && (c_z_reg != '0);
    assign c_done = c_valid_reg && (!c_emit || !job_full);
    assign b_to_c = b_valid_reg && (!c_valid_reg || c_done);

    assign chan_sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
    assign scaled    = SCALED_W'(chan_sum) * SCALED_W'(cfg.max_height);
    assign quot_prod = b_scaled_reg * HEIGHT_RECIP;

    hmesh_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (c_done),
        .waddr (c_x_reg),
        .wdata (c_h_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            above_left_reg <= '0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_inc[ZW-1:0];
                end
                else
                begin
                    col_reg <= col_inc[XW-1:0];
                end
            end

            if (accept)
                b_valid_reg <= 1'b1;
            else if (b_to_c)
                b_valid_reg <= 1'b0;

            if (b_to_c)
                c_valid_reg <= 1'b1;
            else if (c_done)
                c_valid_reg <= 1'b0;

            if (c_done)
            begin
                left_reg       <= c_h_reg;
                above_left_reg <= c_above_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_scaled_reg <= scaled;
            b_x_reg      <= col_reg;
            b_z_reg      <= row_reg;
        end
        if (b_to_c)
        begin
            c_h_reg     <= quot_prod[HEIGHT_SHIFT +: HEIGHT_W];
            c_above_reg <= ram_rdata;
            c_x_reg     <= b_x_reg;
            c_z_reg     <= b_z_reg;
        end
    end

    assign job_push         = c_valid_reg && c_emit && !job_full;
    assign job_x            = c_x_reg - XW'(1);
    assign job_z            = c_z_reg - ZW'(1);
    assign job_h.above_left = above_left_reg;
    assign job_h.left       = left_reg;
    assign job_h.above      = c_above_reg;
    assign job_h.here       = c_h_reg;

endmodule

@@ rtl/hmesh_queue.sv @@
// ----------------------------------------------------------------------------
// hmesh_queue
// Small FIFO of quad requests between the pixel front end and the vertex
// sequencer.
// ----------------------------------------------------------------------------
module hmesh_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wptr_reg;
    logic [AW-1:0]     rptr_reg;
    logic [CW-1:0]     count_reg;
    logic              wr;
    logic              rd;

    assign full  = count_reg == CW'(DEPTH);
    assign empty = count_reg == '0;
    assign wr    = push && !full;
    assign rd    = pop && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            if (rd)
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
            if (wr && !rd)
                count_reg <= count_reg + CW'(1);
            else if (rd && !wr)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/hmesh_back.sv @@
// ----------------------------------------------------------------------------
// hmesh_back
// Vertex sequencer: walks the six corners of a quad, one per cycle unless
// stalled, and computes the texture coordinates into the output register.
// ----------------------------------------------------------------------------
module hmesh_back
    import hmesh_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         job_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] job_x,
    input  logic [$clog2(MAX_ROWS)-1:0]  job_z,
    input  heights_t                     job_h,
    output logic                         job_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [POS_W-1:0]             pos_x,
    output logic [HEIGHT_W-1:0]          pos_y,
    output logic [POS_W-1:0]             pos_z,
    output logic [TEX_W-1:0]             tex_u,
    output logic [TEX_W-1:0]             tex_v,
    output logic                         last_of_quad
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int ZW = $clog2(MAX_ROWS);

    // Corner order of the two triangles of one quad.
    typedef enum logic [2:0]
    {
        CORNER_BASE     = 3'd0,
        CORNER_UP_A     = 3'd1,
        CORNER_RIGHT_A  = 3'd2,
        CORNER_RIGHT_B  = 3'd3,
        CORNER_UP_B     = 3'd4,
        CORNER_FAR      = 3'd5
    } corner_t;

    corner_t             corner_reg;
    corner_t             corner_next;
    logic                out_valid_reg;
    logic [POS_W-1:0]    pos_x_reg;
    logic [HEIGHT_W-1:0] pos_y_reg;
    logic [POS_W-1:0]    pos_z_reg;
    logic [TEX_W-1:0]    tex_u_reg;
    logic [TEX_W-1:0]    tex_v_reg;
    logic                last_reg;

    logic                  step;
    logic [XW-1:0]         vx;
    logic [ZW-1:0]         vz;
    logic [HEIGHT_W-1:0]   vh;
    logic                  vlast;
    logic [XW+TEX_W-1:0]   u_prod;
    logic [ZW+TEX_W-1:0]   v_prod;
    logic [TEX_W-1:0]      u_sat;
    logic [TEX_W-1:0]      v_sat;

    assign step    = job_valid && (!out_valid_reg || pop);
    assign job_pop = step && (corner_reg == CORNER_FAR);

    always_comb
    begin
        vx          = job_x;
        vz          = job_z;
        vh          = job_h.above_left;
        vlast       = 1'b0;
        corner_next = CORNER_BASE;
        case (corner_reg)
            CORNER_BASE:
            begin
                corner_next = CORNER_UP_A;
            end
            CORNER_UP_A:
            begin
                vz          = job_z + ZW'(1);
                vh          = job_h.left;
                corner_next = CORNER_RIGHT_A;
            end
            CORNER_RIGHT_A:
            begin
                vx          = job_x + XW'(1);
                vh          = job_h.above;
                corner_next = CORNER_RIGHT_B;
            end
            CORNER_RIGHT_B:
            begin
                vx          = job_x + XW'(1);
                vh          = job_h.above;
                corner_next = CORNER_UP_B;
            end
            CORNER_UP_B:
            begin
                vz          = job_z + ZW'(1);
                vh          = job_h.left;
                corner_next = CORNER_FAR;
            end
            CORNER_FAR:
            begin
                vx          = job_x + XW'(1);
                vz          = job_z + ZW'(1);
                vh          = job_h.here;
                vlast       = 1'b1;
                corner_next = CORNER_BASE;
            end
            default:
            begin
                corner_next = CORNER_BASE;
            end
        endcase
    end

    assign u_prod = vx * cfg.u_step;
    assign v_prod = vz * cfg.v_step;
    assign u_sat  = (u_prod > (XW+TEX_W)'(TEX_ONE)) ? TEX_ONE : u_prod[TEX_W-1:0];
    assign v_sat  = (v_prod > (ZW+TEX_W)'(TEX_ONE)) ? TEX_ONE : v_prod[TEX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg    <= CORNER_BASE;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            tex_u_reg     <= '0;
            tex_v_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else if (step)
        begin
            corner_reg    <= corner_next;
            out_valid_reg <= 1'b1;
            pos_x_reg     <= POS_W'(vx);
            pos_y_reg     <= vh;
            pos_z_reg     <= POS_W'(vz);
            tex_u_reg     <= u_sat;
            tex_v_reg     <= v_sat;
            last_reg      <= vlast;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign empty        = !out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign last_of_quad = last_reg;

endmodule

@@ rtl/heightmap_to_triangle_mesh.sv @@
// ----------------------------------------------------------------------------
// heightmap_to_triangle_mesh
// The first vertex of a pixel's quad passes stage B, stage C, the job queue and
// the vertex output register. The front end takes no new pixel while one sits
// in stage B, so the line store write lands before the next read. Throughput:
// six vertices per interior pixel, one per cycle on the result port while
// popped. Reset is asynchronous: counters, edge heights and queues are cleared,
// registers take their reset values; the line store is not cleared.
// ----------------------------------------------------------------------------
module heightmap_to_triangle_mesh
    import hmesh_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic                empty,
    input  logic                pop,
    output logic [POS_W-1:0]    pos_x,
    output logic [HEIGHT_W-1:0] pos_y,
    output logic [POS_W-1:0]    pos_z,
    output logic [TEX_W-1:0]    tex_u,
    output logic [TEX_W-1:0]    tex_v,
    output logic                last_of_quad
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int ZW    = $clog2(MAX_ROWS);
    localparam int JOB_W = XW + ZW + $bits(heights_t);

    cfg_t           cfg;
    logic           f_push;
    logic           q_full;
    logic [XW-1:0]  f_x;
    logic [ZW-1:0]  f_z;
    heights_t       f_h;
    logic [JOB_W-1:0] q_wdata;
    logic [JOB_W-1:0] q_rdata;
    logic           q_empty;
    logic           b_pop;
    logic [XW-1:0]  b_x;
    logic [ZW-1:0]  b_z;
    heights_t       b_h;

    hmesh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hmesh_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .full     (full),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .job_push (f_push),
        .job_full (q_full),
        .job_x    (f_x),
        .job_z    (f_z),
        .job_h    (f_h)
    );

    assign q_wdata = {f_x, f_z, f_h};

    hmesh_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (b_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {b_x, b_z, b_h} = q_rdata;

    hmesh_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .job_valid    (!q_empty),
        .job_x        (b_x),
        .job_z        (b_z),
        .job_h        (b_h),
        .job_pop      (b_pop),
        .pop          (pop),
        .empty        (empty),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .last_of_quad (last_of_quad)
    );

endmodule

@@ rtl/hmesh_checker.sv @@
// ----------------------------------------------------------------------------
// hmesh_checker
// Port-level checks of the vertex stream: holding, quad framing, repeated corners and texture range.
// ----------------------------------------------------------------------------
module hmesh_checker
    import hmesh_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input logic [POS_W-1:0]    pos_x,
    input logic [HEIGHT_W-1:0] pos_y,
    input logic [POS_W-1:0]    pos_z,
    input logic [TEX_W-1:0]    tex_u,
    input logic [TEX_W-1:0]    tex_v,
    input logic                last_of_quad
);

    localparam logic [2:0] IDX_UP_A    = 3'd1;
    localparam logic [2:0] IDX_RIGHT_A = 3'd2;
    localparam logic [2:0] IDX_RIGHT_B = 3'd3;
    localparam logic [2:0] IDX_UP_B    = 3'd4;
    localparam logic [2:0] IDX_FAR     = 3'd5;

    localparam int VTX_W = 2 * POS_W + HEIGHT_W + 2 * TEX_W;

    logic [2:0]       idx_reg;
    logic [VTX_W-1:0] up_a_reg;
    logic [VTX_W-1:0] right_a_reg;
    logic [VTX_W-1:0] head;
    logic             taken;

    assign head  = {pos_x, pos_y, pos_z, tex_u, tex_v};
    assign taken = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            up_a_reg    <= '0;
            right_a_reg <= '0;
        end
        else if (taken)
        begin
            idx_reg <= (idx_reg == IDX_FAR) ? '0 : idx_reg + 3'd1;
            if (idx_reg == IDX_UP_A)
                up_a_reg <= head;
            if (idx_reg == IDX_RIGHT_A)
                right_a_reg <= head;
        end
    end

    // A waiting vertex holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(head) && $stable(last_of_quad)))
        else $error("waiting vertex changed before it was taken");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_of_quad == (idx_reg == IDX_FAR)))
        else $error("last_of_quad out of step with the six-vertex framing");

    a_right_dup: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && idx_reg == IDX_RIGHT_B) |-> (head == right_a_reg))
        else $error("fourth vertex differs from the third");

    a_up_dup: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && idx_reg == IDX_UP_B) |-> (head == up_a_reg))
        else $error("fifth vertex differs from the second");

    a_tex_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (tex_u <= TEX_ONE && tex_v <= TEX_ONE))
        else $error("texture coordinate above one");

endmodule

bind heightmap_to_triangle_mesh hmesh_checker u_hmesh_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap mesh generator testbench
// Streams pixels through the block and checks every emitted vertex against a
// cycle-free predictor of the quad builder. Register writes go through the
// configuration port between bursts and are read back. A short directed table
// covers clamped sizes, a shrinking width, saturated texture steps and the
// height extremes; random bursts with random gaps on both sides follow.
// ----------------------------------------------------------------------------
module testbench;
    import hmesh_pkg::*;

    localparam int MAP_MAX_COLS   = 1024;
    localparam int MAP_MAX_ROWS   = 1024;
    localparam int FULL_WHITE     = 3 * 255;
    localparam int REG_COUNT      = 5;
    localparam int REG_SLOTS      = 8;
    localparam logic [2:0] REG_SPARE = 3'(REG_SLOTS - 1);
    localparam int PIXEL_TARGET   = 270;
    localparam int IDLE_CYCLES    = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int PRESSURE_PHASE = 2;
    localparam int DRAIN_LIMIT    = 20000;
    localparam longint RUN_LIMIT_NS = 8_000_000;

    typedef struct packed
    {
        logic [POS_W-1:0]    x;
        logic [HEIGHT_W-1:0] y;
        logic [POS_W-1:0]    z;
        logic [TEX_W-1:0]    u;
        logic [TEX_W-1:0]    v;
        logic                last_flag;
    } vertex_t;

    typedef struct packed
    {
        logic                is_reg;
        logic [2:0]          idx;
        logic [31:0]         value;
        logic [7:0]          r;
        logic [7:0]          g;
        logic [7:0]          b;
        logic                pinned;
        logic [HEIGHT_W-1:0] pinned_h;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                push = 1'b0;
    logic                full;
    logic [7:0]          red = '0;
    logic [7:0]          green = '0;
    logic [7:0]          blue = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [POS_W-1:0]    pos_x;
    logic [HEIGHT_W-1:0] pos_y;
    logic [POS_W-1:0]    pos_z;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
    logic                last_of_quad;

    // Predictor state.
    cfg_t                mesh_cfg;
    logic [HEIGHT_W-1:0] line_heights [MAP_MAX_COLS];
    logic [HEIGHT_W-1:0] left_h;
    logic [HEIGHT_W-1:0] above_left_h;
    int                  col_count;
    int                  row_count;
    vertex_t             pending_vertices [$];

    int mismatches = 0;
    int vertices_checked = 0;
    int pixels_sent = 0;
    int reg_writes = 0;
    int holds_requested = 0;
    int holds_done = 0;
    int sender_calm = 0;
    bit sender_steady = 1'b0;

    heightmap_to_triangle_mesh uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .push(push),
        .full(full),
        .red(red),
        .green(green),
        .blue(blue),
        .empty(empty),
        .pop(pop),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .tex_u(tex_u),
        .tex_v(tex_v),
        .last_of_quad(last_of_quad)
    );

    always #6 clk = ~clk;

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("MISMATCH: %s", what);
        end
    endtask

    function automatic int clamp_size(input logic [10:0] v, input int top);
        if (v < 2)
        begin
            return 2;
        end
        if (v > top)
        begin
            return top;
        end
        return int'(v);
    endfunction

    function automatic logic [TEX_W-1:0] tex_of(input int idx, input logic [TEX_W-1:0] step);
        longint p;
        p = longint'(idx) * longint'(step);
        return (p > 65536) ? TEX_ONE : TEX_W'(p);
    endfunction

    function automatic void add_vertex(input int x, input int z, input logic [HEIGHT_W-1:0] h,
                                       input logic last_flag);
        vertex_t v;
        v.x = POS_W'(x);
        v.y = h;
        v.z = POS_W'(z);
        v.u = tex_of(x, mesh_cfg.u_step);
        v.v = tex_of(z, mesh_cfg.v_step);
        v.last_flag = last_flag;
        pending_vertices.push_back(v);
    endfunction

    // Works out the six vertices that one accepted pixel completes, if any, and
    // advances the raster position. A pinned height replaces the predicted one
    // on the closing vertex.
    function automatic void build_quad(input logic [7:0] r, g, b, input logic pinned,
                                       input logic [HEIGHT_W-1:0] pinned_h);
        int                  sum;
        int                  width;
        int                  rows;
        int                  x;
        int                  z;
        logic [HEIGHT_W-1:0] h;
        logic [HEIGHT_W-1:0] above;
        sum = int'(r) + int'(g) + int'(b);
        h = HEIGHT_W'((longint'(sum) * longint'(mesh_cfg.max_height)) / FULL_WHITE);
        width = clamp_size(mesh_cfg.map_width, MAP_MAX_COLS);
        rows = clamp_size(mesh_cfg.map_rows, MAP_MAX_ROWS);
        x = col_count;
        z = row_count;
        above = line_heights[x];
        if (x > 0 && z > 0)
        begin
            add_vertex(x - 1, z - 1, above_left_h, 1'b0);
            add_vertex(x - 1, z, left_h, 1'b0);
            add_vertex(x, z - 1, above, 1'b0);
            add_vertex(x, z - 1, above, 1'b0);
            add_vertex(x - 1, z, left_h, 1'b0);
            add_vertex(x, z, pinned ? pinned_h : h, 1'b1);
        end
        above_left_h = above;
        line_heights[x] = h;
        left_h = h;
        col_count = x + 1;
        if (col_count >= width)
        begin
            col_count = 0;
            row_count = z + 1;
            if (row_count >= rows)
            begin
                row_count = 0;
            end
        end
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int pick_size(input int small_top);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1);
            1: return $urandom_range(1024, 2047);
            default: return $urandom_range(2, small_top);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd65536;
            2: return 32'h1FFFF;
            3: return 32'($urandom_range(0, 17'h1FFFF));
            default: return 32'($urandom_range(1, 20000));
        endcase
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [31:0] value);
        stim_row_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx = idx;
        s.value = value;
        return s;
    endfunction

    function automatic stim_row_t pixel_row(input logic [7:0] r, g, b);
        stim_row_t s;
        s = '0;
        s.r = r;
        s.g = g;
        s.b = b;
        return s;
    endfunction

    function automatic stim_row_t pinned_row(input logic [7:0] r, g, b,
                                             input logic [HEIGHT_W-1:0] h);
        stim_row_t s;
        s = pixel_row(r, g, b);
        s.pinned = 1'b1;
        s.pinned_h = h;
        return s;
    endfunction

    // Called at a falling edge. Waits until every expected vertex is out, then
    // lets the pipeline drain pixels that produce nothing.
    task automatic settle();
        push <= 1'b0;
        while (pending_vertices.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] held;
        held = '0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        reg_writes++;
        if (idx < REG_COUNT)
        begin
            case (reg_idx_t'(idx))
                REG_MAP_WIDTH:
                begin
                    mesh_cfg.map_width = value[10:0];
                    held = 32'(mesh_cfg.map_width);
                end
                REG_MAP_ROWS:
                begin
                    mesh_cfg.map_rows = value[10:0];
                    held = 32'(mesh_cfg.map_rows);
                end
                REG_MAX_HEIGHT:
                begin
                    mesh_cfg.max_height = value[15:0];
                    held = 32'(mesh_cfg.max_height);
                end
                REG_U_STEP:
                begin
                    mesh_cfg.u_step = value[16:0];
                    held = 32'(mesh_cfg.u_step);
                end
                REG_V_STEP:
                begin
                    mesh_cfg.v_step = value[16:0];
                    held = 32'(mesh_cfg.v_step);
                end
                default: held = '0;
            endcase
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== held)
            begin
                log_mismatch($sformatf("register %0d read back %0h, expected %0h",
                                       idx, prdata, held));
            end
            @(negedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Called at a falling edge; returns at a falling edge with push still high
    // when no gap follows.
    task automatic send_pixel(input logic [7:0] r, g, b, input logic pinned,
                              input logic [HEIGHT_W-1:0] pinned_h);
        int gap;
        red <= r;
        green <= g;
        blue <= b;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        build_quad(r, g, b, pinned, pinned_h);
        pixels_sent++;
        @(negedge clk);
        gap = 0;
        if (sender_steady)
        begin
            gap = 0;
        end
        else if (sender_calm > 0)
        begin
            sender_calm--;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            sender_calm = $urandom_range(20, 60);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin : vertex_check
        vertex_t want;
        string   want_txt;
        if (rst_n && pop && !empty)
        begin
            if (pending_vertices.size() == 0)
            begin
                log_mismatch($sformatf("vertex with none expected: x=%0d y=%0d z=%0d",
                                       pos_x, pos_y, pos_z));
            end
            else
            begin
                want = pending_vertices.pop_front();
                vertices_checked++;
                if (pos_x !== want.x || pos_y !== want.y || pos_z !== want.z ||
                    tex_u !== want.u || tex_v !== want.v || last_of_quad !== want.last_flag)
                begin
                    want_txt = $sformatf(
                        "vertex %0d expected x=%0d y=%0d z=%0d u=%0d v=%0d last=%0d",
                        vertices_checked, want.x, want.y, want.z, want.u, want.v,
                        want.last_flag);
                    log_mismatch({want_txt, $sformatf(
                        ", got x=%0d y=%0d z=%0d u=%0d v=%0d last=%0d",
                        pos_x, pos_y, pos_z, tex_u, tex_v, last_of_quad)});
                end
            end
        end
    end

    // Result side: random stalls, calm stretches, and a long hold-off on request.
    initial
    begin : result_taker
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_requested)
            begin
                holds_done++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (calm_left > 0)
                begin
                    calm_left--;
                end
                else if ($urandom_range(0, 59) == 0)
                begin
                    calm_left = $urandom_range(30, 120);
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t directed_rows [$];
        int        phase;
        int        burst;
        int        cur_w;
        int        cand;
        int        width;
        int        rows;
        int        remaining;
        int        drain;
        foreach (line_heights[i])
        begin
            line_heights[i] = '0;
        end
        mesh_cfg = CFG_RESET;
        left_h = '0;
        above_left_h = '0;
        col_count = 0;
        row_count = 0;

        // Sizes below two clamp to two; a white pixel then reaches the full
        // height and black stays at zero.
        directed_rows = '{
            reg_row(REG_MAP_WIDTH, 32'd0),
            reg_row(REG_MAP_ROWS, 32'd1),
            reg_row(REG_MAX_HEIGHT, 32'd65535),
            reg_row(REG_U_STEP, 32'd65536),
            reg_row(REG_V_STEP, 32'h1FFFF),
            pixel_row(8'd0, 8'd0, 8'd0),
            pixel_row(8'd255, 8'd255, 8'd255),
            pixel_row(8'd255, 8'd255, 8'd255),
            pinned_row(8'd255, 8'd255, 8'd255, 16'd65535),
            pixel_row(8'd0, 8'd0, 8'd0),
            pixel_row(8'd0, 8'd0, 8'd0),
            pixel_row(8'd0, 8'd0, 8'd0),
            pinned_row(8'd0, 8'd0, 8'd0, 16'd0),
            reg_row(REG_MAX_HEIGHT, 32'd0),
            pixel_row(8'd255, 8'd0, 8'd0),
            pixel_row(8'd0, 8'd255, 8'd0),
            pixel_row(8'd0, 8'd0, 8'd255),
            pinned_row(8'd255, 8'd255, 8'd255, 16'd0),
            // Oversized width clamps to the line store size; an unmapped
            // register slot is written and must change nothing.
            reg_row(REG_MAP_WIDTH, 32'd2047),
            reg_row(REG_MAP_ROWS, 32'd2047),
            reg_row(REG_MAX_HEIGHT, 32'd256),
            reg_row(REG_U_STEP, 32'd0),
            reg_row(REG_V_STEP, 32'd1),
            reg_row(REG_SPARE, 32'hFFFF_FFFF),
            pixel_row(8'd10, 8'd20, 8'd30),
            pixel_row(8'd255, 8'd0, 8'd255),
            pixel_row(8'd128, 8'd128, 8'd128),
            pixel_row(8'd1, 8'd2, 8'd3),
            pixel_row(8'd200, 8'd100, 8'd50),
            // Width shrinks below the current column: that pixel still lands
            // at its column, then the row wraps.
            reg_row(REG_MAP_WIDTH, 32'd3),
            pixel_row(8'd0, 8'd255, 8'd255),
            pixel_row(8'd7, 8'd77, 8'd177),
            pixel_row(8'd254, 8'd1, 8'd127),
            pixel_row(8'd64, 8'd32, 8'd16),
            pixel_row(8'd85, 8'd170, 8'd85),
            pixel_row(8'd170, 8'd85, 8'd170),
            // Row count shrinks to the current row: the row finishes, then the
            // map starts over.
            reg_row(REG_MAP_ROWS, 32'd0),
            pixel_row(8'd99, 8'd199, 8'd9)
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                settle();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end
            else
            begin
                send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                           directed_rows[i].pinned, directed_rows[i].pinned_h);
            end
        end

        phase = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            settle();
            if (phase == PRESSURE_PHASE)
            begin
                // Narrow map, tall rows: each second-column pixel below the first row closes a
                // quad while the result side holds off and the block backs up.
                write_reg(REG_MAP_WIDTH, 32'd2);
                write_reg(REG_MAP_ROWS, 32'd1024);
                sender_steady = 1'b1;
                holds_requested++;
                burst = 48;
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        // The line store holds only the columns written so
                        // far, so the width may grow only at the top of a map.
                        cur_w = clamp_size(mesh_cfg.map_width, MAP_MAX_COLS);
                        cand = pick_size(8);
                        if (clamp_size(11'(cand), MAP_MAX_COLS) > cur_w &&
                            !(col_count == 0 && row_count == 0))
                        begin
                            cand = $urandom_range(0, cur_w);
                        end
                        write_reg(REG_MAP_WIDTH, 32'(cand));
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        write_reg(REG_MAP_ROWS, 32'(pick_size(6)));
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        case ($urandom_range(0, 3))
                            0: write_reg(REG_MAX_HEIGHT, 32'd0);
                            1: write_reg(REG_MAX_HEIGHT, 32'd65535);
                            default: write_reg(REG_MAX_HEIGHT, 32'($urandom_range(0, 65535)));
                        endcase
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        write_reg(REG_U_STEP, pick_step());
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        write_reg(REG_V_STEP, pick_step());
                    end
                    if ($urandom_range(0, 5) == 0)
                    begin
                        write_reg(3'($urandom_range(REG_COUNT, REG_SLOTS - 1)), $urandom);
                    end
                end
                burst = $urandom_range(8, 30);
                // Sometimes run exactly to the end of the map so that the next
                // phase may widen it.
                width = clamp_size(mesh_cfg.map_width, MAP_MAX_COLS);
                rows = clamp_size(mesh_cfg.map_rows, MAP_MAX_ROWS);
                remaining = (col_count >= width) ? 1 : width - col_count;
                if (row_count + 1 < rows)
                begin
                    remaining += (rows - row_count - 1) * width;
                end
                if ($urandom_range(0, 1) == 1 && remaining <= 60)
                begin
                    burst = remaining;
                end
            end
            if (burst > PIXEL_TARGET - pixels_sent)
            begin
                burst = PIXEL_TARGET - pixels_sent;
            end
            repeat (burst) send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
            sender_steady = 1'b0;
            phase++;
        end

        push <= 1'b0;
        drain = 0;
        while (pending_vertices.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        if (pending_vertices.size() != 0)
        begin
            log_mismatch($sformatf("%0d expected vertices never came out",
                                   pending_vertices.size()));
        end
        repeat (IDLE_CYCLES) @(negedge clk);

        $display("Run covered %0d pixels, %0d vertices checked, %0d register writes, %0d mismatches.",
                 pixels_sent, vertices_checked, reg_writes, mismatches);
        $display("Clamped to full-size maps, saturated texture steps, %0d long result hold-off(s).",
                 holds_done);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
